@@ rtl/max_heap_priority_queue_defines.svh @@
// Assertion macros used by the heap queue back end.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define MHPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MHPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Kind and status codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam logic [2:0] K_LOAD    = 3'd0;
  localparam logic [2:0] K_BUILD   = 3'd1;
  localparam logic [2:0] K_INSERT  = 3'd2;
  localparam logic [2:0] K_EXTRACT = 3'd3;
  localparam logic [2:0] K_INCR    = 3'd4;
  localparam logic [2:0] K_SORT    = 3'd5;
  localparam logic [2:0] K_CLEAR   = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_SMALLER = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADPOS  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [5:0]  position;
  } cmd_t;

endpackage

@@ rtl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

@@ rtl/mhpq_front.sv @@
// ----------------------------------------------------------------------------
// mhpq_front
// Accepts items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mhpq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [31:0]       in_value,
  input  logic [5:0]        in_position,
  output logic              q_valid,
  input  logic              q_take,
  output mhpq_pkg::cmd_t    q_cmd
);
  import mhpq_pkg::*;

  cmd_t       ent_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = ent_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (q_take && q_valid);
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= '{kind: in_kind, value: in_value, position: in_position};
    end
  end
endmodule

@@ rtl/mhpq_back.sv @@
// ----------------------------------------------------------------------------
// mhpq_back
// Sequencer that runs one heap operation at a time over the key RAM.
// ----------------------------------------------------------------------------
module mhpq_back #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_take,
  input  mhpq_pkg::cmd_t    q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_value_res,
  output logic [2:0]        out_status,
  output logic [6:0]        out_count,
  output logic              out_last
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = 7;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DRD   = 5'd1;  // sift down: read children
  localparam logic [4:0] S_DCMP  = 5'd2;  // sift down: compare, move hole
  localparam logic [4:0] S_URD   = 5'd3;  // sift up: read parent
  localparam logic [4:0] S_UCMP  = 5'd4;
  localparam logic [4:0] S_EXRD  = 5'd5;  // extract: read root and last
  localparam logic [4:0] S_EXWR  = 5'd6;
  localparam logic [4:0] S_SWRD  = 5'd7;  // sort: read root and end
  localparam logic [4:0] S_SWWR  = 5'd8;
  localparam logic [4:0] S_EMRD  = 5'd9;  // sort: emit keys
  localparam logic [4:0] S_EMWT  = 5'd10;
  localparam logic [4:0] S_MXRD  = 5'd11; // read root for the reply
  localparam logic [4:0] S_MXWT  = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;
  localparam logic [4:0] S_IKRD  = 5'd14; // increase key: read old key
  localparam logic [4:0] S_IKCMP = 5'd15;
  localparam logic [4:0] S_BRD   = 5'd16; // build: read node key
  localparam logic [4:0] S_BLD   = 5'd17;

  // what follows a sift-down pass
  localparam logic [1:0] R_BUILD = 2'd0;
  localparam logic [1:0] R_EXT   = 2'd1;
  localparam logic [1:0] R_SORT  = 2'd2;

  logic [4:0]           st_r, st_nxt;
  logic [1:0]           ret_r, ret_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        end_r, end_nxt;    // sift-down bound / sort end
  logic [CW-1:0]        bi_r, bi_nxt;      // build index
  logic [CW-1:0]        ix_r, ix_nxt;      // hole position
  logic [CW-1:0]        em_r, em_nxt;
  logic [KEY_WIDTH-1:0] cur_r, cur_nxt;    // key carried by the hole
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic [31:0]          res_v_r, res_v_nxt;
  logic [2:0]           res_s_r, res_s_nxt;
  logic                 ov_valid_r, ov_valid_nxt;
  logic [31:0]          ov_r, ov_nxt;
  logic [2:0]           os_r, os_nxt;
  logic [6:0]           oc_r, oc_nxt;
  logic                 ol_r, ol_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, ra, rb;
  logic [KEY_WIDTH-1:0] wdata, da, db;

  logic [CW:0]          lch, rch;
  logic [CW-1:0]        par, cm1;
  logic [KEY_WIDTH-1:0] vkey;

  mhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
  );

  assign lch  = {ix_r, 1'b1};
  assign rch  = {ix_r, 1'b0} + 8'd2;
  assign par  = (ix_r - 7'd1) >> 1;
  assign cm1  = cnt_r - 7'd1;
  assign vkey = KEY_WIDTH'($signed(q_cmd.value));

  assign out_valid     = ov_valid_r;
  assign out_value_res = ov_r;
  assign out_status    = os_r;
  assign out_count     = oc_r;
  assign out_last      = ol_r;

  function automatic logic [31:0] to32(input logic [KEY_WIDTH-1:0] k);
    logic signed [63:0] w;
    begin
      w = 64'($signed(k));
      return w[31:0];
    end
  endfunction

  always_comb begin
    logic                 done_dn;
    logic                 rin, pick_l, pick_r;
    logic [KEY_WIDTH-1:0] big;
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r; end_nxt = end_r;
    bi_nxt = bi_r; ix_nxt = ix_r; em_nxt = em_r; cur_nxt = cur_r;
    key_nxt = key_r; kind_nxt = kind_r;
    res_v_nxt = res_v_r; res_s_nxt = res_s_r;
    ov_nxt = ov_r; os_nxt = os_r; oc_nxt = oc_r; ol_nxt = ol_r;
    ov_valid_nxt = ov_valid_r && !out_ready;
    we = 1'b0; waddr = '0; wdata = '0; ra = '0; rb = '0;
    q_take = 1'b0;
    done_dn = 1'b0; rin = 1'b0; pick_l = 1'b0; pick_r = 1'b0; big = '0;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          kind_nxt  = q_cmd.kind;
          key_nxt   = vkey;
          res_s_nxt = ST_OK;
          unique case (q_cmd.kind)
            K_LOAD, K_INSERT: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                res_s_nxt = ST_FULL;
                st_nxt    = S_MXRD;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                if (q_cmd.kind == K_INSERT) begin
                  cur_nxt = vkey;
                  ix_nxt  = cnt_r;
                  st_nxt  = S_URD;
                end else begin
                  we = 1'b1; waddr = cnt_r[AW-1:0]; wdata = vkey;
                  st_nxt = S_MXRD;
                end
              end
            end
            K_BUILD: begin
              if (cnt_r == '0) begin
                st_nxt = S_MXRD;
              end else begin
                bi_nxt = cm1; end_nxt = cnt_r; ret_nxt = R_BUILD; st_nxt = S_BRD;
              end
            end
            K_EXTRACT: begin
              if (cnt_r == '0) begin
                res_v_nxt = '0; res_s_nxt = ST_EMPTY; st_nxt = S_OUT;
              end else begin
                st_nxt = S_EXRD;
              end
            end
            K_INCR: begin
              if (CW'(q_cmd.position) >= cnt_r) begin
                res_s_nxt = ST_BADPOS; st_nxt = S_MXRD;
              end else begin
                ix_nxt = CW'(q_cmd.position); st_nxt = S_IKRD;
              end
            end
            K_SORT: begin
              if (cnt_r == '0) begin
                res_v_nxt = '0; res_s_nxt = ST_EMPTY; st_nxt = S_OUT;
              end else if (cnt_r == CW'(1)) begin
                em_nxt = '0; st_nxt = S_EMRD;
              end else begin
                end_nxt = cm1; ret_nxt = R_SORT; st_nxt = S_SWRD;
              end
            end
            K_CLEAR: begin
              cnt_nxt = '0; st_nxt = S_MXRD;
            end
            default: st_nxt = S_MXRD;
          endcase
        end
      end
      S_IKRD: begin
        ra = ix_r[AW-1:0]; st_nxt = S_IKCMP;
      end
      S_IKCMP: begin
        if ($signed(key_r) < $signed(da)) begin
          res_s_nxt = ST_SMALLER; st_nxt = S_MXRD;
        end else begin
          cur_nxt = key_r; st_nxt = S_URD;
        end
      end
      S_URD: begin
        if (ix_r == '0) begin
          we = 1'b1; waddr = '0; wdata = cur_r;
          st_nxt = S_MXRD;
        end else begin
          ra = par[AW-1:0]; st_nxt = S_UCMP;
        end
      end
      S_UCMP: begin
        if ($signed(da) < $signed(cur_r)) begin
          // pull the parent down into the hole and climb
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = da;
          ix_nxt = par;
          st_nxt = S_URD;
        end else begin
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = cur_r;
          st_nxt = S_MXRD;
        end
      end
      S_EXRD: begin
        ra = '0; rb = cm1[AW-1:0]; st_nxt = S_EXWR;
      end
      S_EXWR: begin
        res_v_nxt = to32(da); res_s_nxt = ST_OK;
        cnt_nxt = cm1;
        cur_nxt = db; ix_nxt = '0; end_nxt = cm1; ret_nxt = R_EXT;
        st_nxt = S_DRD;
      end
      S_BRD: begin
        ra = bi_r[AW-1:0]; st_nxt = S_BLD;
      end
      S_BLD: begin
        cur_nxt = da; ix_nxt = bi_r; st_nxt = S_DRD;
      end
      S_SWRD: begin
        ra = '0; rb = end_r[AW-1:0]; st_nxt = S_SWWR;
      end
      S_SWWR: begin
        // move root to the sorted tail; old tail goes through the sift
        we = 1'b1; waddr = end_r[AW-1:0]; wdata = da;
        cur_nxt = db; ix_nxt = '0;
        st_nxt = S_DRD;
      end
      S_DRD: begin
        if (lch >= {1'b0, end_r}) begin
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = cur_r;
          done_dn = 1'b1;
        end else begin
          ra = lch[AW-1:0]; rb = rch[AW-1:0]; st_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        // da: left child, db: right child
        rin = (rch < {1'b0, end_r});
        big = cur_r;
        if ($signed(da) > $signed(big)) begin
          pick_l = 1'b1; big = da;
        end
        if (rin && $signed(db) > $signed(big)) begin
          pick_l = 1'b0; pick_r = 1'b1;
        end
        if (pick_l) begin
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = da;
          ix_nxt = lch[CW-1:0]; st_nxt = S_DRD;
        end else if (pick_r) begin
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = db;
          ix_nxt = rch[CW-1:0]; st_nxt = S_DRD;
        end else begin
          we = 1'b1; waddr = ix_r[AW-1:0]; wdata = cur_r;
          done_dn = 1'b1;
        end
      end
      S_EMRD: begin
        ra = em_r[AW-1:0]; st_nxt = S_EMWT;
      end
      S_EMWT: begin
        // hold the read address so the key stays on da while stalled
        ra = em_r[AW-1:0];
        if (!ov_valid_r || out_ready) begin
          ov_valid_nxt = 1'b1;
          ov_nxt = to32(da); os_nxt = ST_OK; oc_nxt = cnt_r;
          ol_nxt = (em_r == cm1);
          if (em_r == cm1) begin
            // rebuild the heap after the run
            bi_nxt = cm1; end_nxt = cnt_r; ret_nxt = R_BUILD; st_nxt = S_BRD;
          end else begin
            em_nxt = em_r + 1'b1; st_nxt = S_EMRD;
          end
        end
      end
      S_MXRD: begin
        ra = '0; st_nxt = S_MXWT;
      end
      S_MXWT: begin
        res_v_nxt = (cnt_r == '0) ? '0 : to32(da);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_valid_r || out_ready) begin
          ov_valid_nxt = 1'b1;
          ov_nxt = res_v_r; os_nxt = res_s_r; oc_nxt = cnt_r; ol_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (done_dn) begin
      unique case (ret_r)
        R_EXT: st_nxt = S_OUT;
        R_SORT: begin
          if (end_r == CW'(1)) begin
            em_nxt = '0; st_nxt = S_EMRD;
          end else begin
            end_nxt = end_r - 1'b1; st_nxt = S_SWRD;
          end
        end
        default: begin
          if (bi_r == '0) begin
            st_nxt = (kind_r == K_SORT) ? S_IDLE : S_MXRD;
          end else begin
            bi_nxt = bi_r - 1'b1; st_nxt = S_BRD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      ret_r      <= R_BUILD;
      cnt_r      <= '0;
      end_r      <= '0;
      bi_r       <= '0;
      ix_r       <= '0;
      em_r       <= '0;
      cur_r      <= '0;
      key_r      <= '0;
      kind_r     <= K_LOAD;
      res_v_r    <= '0;
      res_s_r    <= ST_OK;
      ov_valid_r <= 1'b0;
      ov_r       <= '0;
      os_r       <= ST_OK;
      oc_r       <= '0;
      ol_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ret_r      <= ret_nxt;
      cnt_r      <= cnt_nxt;
      end_r      <= end_nxt;
      bi_r       <= bi_nxt;
      ix_r       <= ix_nxt;
      em_r       <= em_nxt;
      cur_r      <= cur_nxt;
      key_r      <= key_nxt;
      kind_r     <= kind_nxt;
      res_v_r    <= res_v_nxt;
      res_s_r    <= res_s_nxt;
      ov_valid_r <= ov_valid_nxt;
      ov_r       <= ov_nxt;
      os_r       <= os_nxt;
      oc_r       <= oc_nxt;
      ol_r       <= ol_nxt;
    end
  end

  `MHPQ_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CW'(CAPACITY), "count beyond capacity")
  `MHPQ_ASSERT_IMP(a_take_idle, q_take, st_r == S_IDLE, "queue read while busy")
  `MHPQ_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_value_res),
                   "result dropped while stalled")
endmodule

@@ rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue of signed keys with in-place heapsort. Items
// enter a two-deep command queue and are run one at a time by a sequencer over
// a dual-read key RAM with one write port. Load, clear and an empty build end
// with a root read for the reply; insert and increase-key climb one level per
// parent read (increase-key reads the old key first); extract reads the root
// and the last key, then sifts down one level per child read. Build reads each
// node and sifts it down, from the last node to the root; sort swaps the root
// to the tail and sifts for every key but the last, emits the sorted keys in
// order, then rebuilds the heap. A stalled result holds the sequencer until it
// is taken.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Top level: command front end and heap sequencer back end.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value_res,
  output logic [2:0]  out_status,
  output logic [6:0]  out_count,
  output logic        out_last
);
  import mhpq_pkg::*;

  logic q_valid, q_take;
  cmd_t q_cmd;

  mhpq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_value, .in_position,
    .q_valid, .q_take, .q_cmd
  );

  mhpq_back #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_cmd,
    .out_valid, .out_ready, .out_value_res, .out_status, .out_count, .out_last
  );
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the max-heap priority queue against a behavioral heap of its own.
// Items are queued by an initial block, driven at the falling edge and the
// results are compared field by field with predicted ones at the rising edge.
// ----------------------------------------------------------------------------
module tb;
  import mhpq_pkg::*;

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] K_SPARE = 3'd7;

  typedef struct packed {
    logic [31:0] value_res;
    logic [2:0]  status;
    logic [6:0]  count;
    logic        last;
  } heap_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_value = '0;
  logic [5:0]  in_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value_res;
  logic [2:0]  out_status;
  logic [6:0]  out_count;
  logic        out_last;
  logic        in_acc = 1'b0;

  max_heap_priority_queue i_dut (.*);

  always #1 clk = ~clk;

  cmd_t        pending_cmds[$];
  heap_res_t   expected_res[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // Shadow heap.
  logic signed [31:0] keys[CAP];
  int                 nkeys = 0;

  function automatic void add_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void swap_keys(int a, int b);
    logic signed [31:0] t;
    t = keys[a]; keys[a] = keys[b]; keys[b] = t;
  endfunction

  function automatic void sink(int i, int stop);
    int l, r, big;
    forever begin
      l = 2 * i + 1; r = 2 * i + 2; big = i;
      if (l < stop && keys[l] > keys[big]) big = l;
      if (r < stop && keys[r] > keys[big]) big = r;
      if (big == i) return;
      swap_keys(i, big);
      i = big;
    end
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(keys[p] < keys[i])) return;
      swap_keys(i, p);
      i = p;
    end
  endfunction

  function automatic void heapify();
    for (int i = nkeys - 1; i >= 0; i--) sink(i, nkeys);
  endfunction

  function automatic void push_res(logic [31:0] v, logic [2:0] st, logic lst);
    heap_res_t r;
    r.value_res = v; r.status = st; r.count = nkeys[6:0]; r.last = lst;
    expected_res.insert(expected_res.size(), r);
  endfunction

  function automatic void predict_heap(cmd_t c);
    logic [2:0]         st;
    logic signed [31:0] top;
    int                 n;
    st = ST_OK;
    case (c.kind)
      K_LOAD, K_INSERT: begin
        if (nkeys >= CAP) st = ST_FULL;
        else begin
          keys[nkeys] = c.value;
          nkeys++;
          if (c.kind == K_INSERT) rise(nkeys - 1);
        end
      end
      K_BUILD: heapify();
      K_EXTRACT: begin
        if (nkeys == 0) begin
          push_res('0, ST_EMPTY, 1'b1);
          return;
        end
        top = keys[0];
        nkeys--;
        keys[0] = keys[nkeys];
        sink(0, nkeys);
        push_res(top, ST_OK, 1'b1);
        return;
      end
      K_INCR: begin
        if (int'(c.position) >= nkeys) st = ST_BADPOS;
        else if ($signed(c.value) < keys[c.position]) st = ST_SMALLER;
        else begin
          keys[c.position] = c.value;
          rise(c.position);
        end
      end
      K_SORT: begin
        n = nkeys;
        if (n == 0) begin
          push_res('0, ST_EMPTY, 1'b1);
          return;
        end
        for (int i = n - 1; i >= 1; i--) begin
          swap_keys(0, i);
          sink(0, i);
        end
        for (int i = 0; i < n; i++) push_res(keys[i], ST_OK, i == n - 1);
        heapify();
        return;
      end
      K_CLEAR: nkeys = 0;
      default: ;
    endcase
    push_res(nkeys > 0 ? keys[0] : 32'sd0, st, 1'b1);
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t mk(logic [2:0] k, logic [31:0] v, logic [5:0] p);
    cmd_t c;
    c.kind = k; c.value = v; c.position = p;
    return c;
  endfunction

  // Driver: present the head of the queue, hold until transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_acc) begin
        // hold
      end else if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        in_kind     <= pending_cmds[0].kind;
        in_value    <= pending_cmds[0].value;
        in_position <= pending_cmds[0].position;
        void'(pending_cmds.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input transfer, check on output transfer.
  always @(posedge clk) begin
    heap_res_t got, want;
    logic      moved;
    moved = 1'b0;
    in_acc <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_heap(mk(in_kind, in_value, in_position));
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got = {out_value_res, out_status, out_count, out_last};
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp val %h st %0d cnt %0d last %b, %s %h st %0d cnt %0d last %b",
                       want.value_res, want.status, want.count, want.last,
                       "got val", got.value_res, got.status, got.count, got.last);
          end
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Random phases with changing idle ratios; the first also carries the
    // directed part: empty cases, full store, bad position, smaller key, sort run.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 34 : 0;
      if (ph == 0) begin
        add_cmd(mk(K_EXTRACT, '0, '0));
        add_cmd(mk(K_SORT, '0, '0));
        add_cmd(mk(K_BUILD, '0, '0));
        add_cmd(mk(K_CLEAR, '0, '0));
        add_cmd(mk(K_INCR, 32'd5, '0));
        add_cmd(mk(K_SPARE, '0, '0));
        add_cmd(mk(K_LOAD, 32'h8000_0000, '0));
        add_cmd(mk(K_LOAD, 32'h7fff_ffff, '0));
        add_cmd(mk(K_LOAD, 32'd3, '0));
        add_cmd(mk(K_LOAD, 32'd3, '0));
        add_cmd(mk(K_BUILD, '0, '0));
        add_cmd(mk(K_INCR, 32'h8000_0000, 6'd1));
        add_cmd(mk(K_INCR, 32'd9, 6'd63));
        add_cmd(mk(K_INCR, 32'h7fff_ffff, 6'd3));
        add_cmd(mk(K_INSERT, 32'hffff_ffff, '0));
        add_cmd(mk(K_SORT, '0, '0));
        add_cmd(mk(K_EXTRACT, '0, '0));
        add_cmd(mk(K_SPARE, '0, '0));
        for (int i = 0; i < 60; i++) add_cmd(mk(K_INSERT, rand_key(), '0));
        add_cmd(mk(K_INSERT, 32'd1, '0));
        add_cmd(mk(K_LOAD, 32'd1, '0));
        add_cmd(mk(K_INCR, 32'h7fff_ffff, 6'd63));
        add_cmd(mk(K_SORT, '0, '0));
        add_cmd(mk(K_CLEAR, '0, '0));
      end
      for (int i = 0; i < 6; i++) begin
        n = $urandom_range(0, 99);
        if (n < 30) add_cmd(mk(K_INSERT, rand_key(), 6'($urandom)));
        else if (n < 45) add_cmd(mk(K_LOAD, rand_key(), 6'($urandom)));
        else if (n < 65) add_cmd(mk(K_EXTRACT, $urandom, 6'($urandom)));
        else if (n < 80)
          add_cmd(mk(K_INCR, rand_key(), 6'($urandom_range(0, 9))));
        else if (n < 86) add_cmd(mk(K_BUILD, $urandom, 6'($urandom)));
        else if (n < 92) add_cmd(mk(K_SORT, $urandom, 6'($urandom)));
        else if (n < 96) add_cmd(mk(K_INCR, rand_key(), 6'($urandom)));
        else if (n < 98) add_cmd(mk(K_SPARE, $urandom, 6'($urandom)));
        else add_cmd(mk(K_CLEAR, $urandom, 6'($urandom)));
      end
      drain();
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_front.sv
rtl/mhpq_back.sv
rtl/max_heap_priority_queue.sv
tb/sv/tb.sv
